// ===== hdl/round_robin_timeslice_scheduler_defines.svh =====
// ----------------------------------------------------------------------------
// Round-robin timeslice scheduler: assertion macros
// Assertion forms for the scheduler datapath. Each expects clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_TIMESLICE_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TIMESLICE_SCHEDULER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define RRTS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rrts: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define RRTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rrts: next-cycle check failed");

`endif

// ===== hdl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// Round-robin timeslice scheduler package
// Controller states, command and status bundles, register indexes and
// field widths shared by the controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // Field widths
  localparam int unsigned PRIO_W  = 3;
  localparam int unsigned SLEEP_W = 16;
  localparam int unsigned STACK_W = 32;
  localparam int unsigned SLICE_W = 11;
  localparam int unsigned SLOTF_W = 4;
  localparam int unsigned SCALE_W = 8;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned CFG_W   = 8;

  // Configuration register indexes
  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // Input opcodes
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Configuration reset values
  localparam logic [SCALE_W-1:0] SCALE_RST = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_RST = 5'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_TICK_RD,
    ST_TICK_EV,
    ST_MIN,
    ST_WALK,
    ST_OUT_RD,
    ST_OUT_WR
  } state_t;

  typedef struct packed {
    logic latch_in;    // capture the input transaction
    logic load_wr;     // write the loaded slot
    logic tick_rd;     // read the running slot's priority and slice
    logic tick_ev;     // evaluate the slice, reload or decrement
    logic min_step;    // one step of the least-sleep pass
    logic walk_start;  // set up the round-robin walk
    logic walk_step;   // one step of the walk
    logic out_rd;      // read the running slot's stack pointer
    logic out_wr;      // fill the result register
  } cmd_t;

  typedef struct packed {
    logic slice_zero;  // running slot's slice has expired
    logic pass_done;   // all ring entries issued and folded
    logic out_free;    // result register can take a new transaction
  } sts_t;

endpackage

// ===== hdl/round_robin_timeslice_scheduler.sv =====
// ----------------------------------------------------------------------------
// Round-robin timeslice scheduler
// Task slot ring with per-slot timeslices; ticks rotate to the next awake
// slot when the running slot's slice expires, loads fill a slot.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  opcode, slot_index, task_priority,
//                                task_sleep, task_stack
//  out      out_valid/out_stall  current_task, stack_pointer, switched
//  cfg      cfg_we               cfg_index, cfg_wdata
//
//  A load writes its slot; a tick reads and evaluates the running slot's
//  slice, and on expiry runs the least-sleep pass and the walk, which each
//  stream one slot a cycle through the sleep table's single read port.
//  One transaction is in work at a time; the result register lets the next
//  transaction start while a result waits on out_stall.
//  Reset (rst_n low, synchronous) clears the running slot and the
//  configuration; the slot tables are left as they are.
// ----------------------------------------------------------------------------
module round_robin_timeslice_scheduler #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_opcode,
  input  logic [rrts_pkg::SLOTF_W-1:0]  in_slot_index,
  input  logic [rrts_pkg::PRIO_W-1:0]   in_task_priority,
  input  logic [rrts_pkg::SLEEP_W-1:0]  in_task_sleep,
  input  logic [rrts_pkg::STACK_W-1:0]  in_task_stack,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrts_pkg::SLOTF_W-1:0]  out_current_task,
  output logic [rrts_pkg::STACK_W-1:0]  out_stack_pointer,
  output logic                          out_switched,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rrts_pkg::CFG_W-1:0]    cfg_wdata
);

  rrts_pkg::cmd_t cmd;
  rrts_pkg::sts_t sts;

  // Sequencer
  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Tables, counters and result register
  rrts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_slot_index     (in_slot_index),
    .in_task_priority  (in_task_priority),
    .in_task_sleep     (in_task_sleep),
    .in_task_stack     (in_task_stack),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_current_task  (out_current_task),
    .out_stack_pointer (out_stack_pointer),
    .out_switched      (out_switched)
  );

endmodule

// ===== hdl/rrts_ctrl.sv =====
// ----------------------------------------------------------------------------
// Round-robin timeslice scheduler: controller
// Sequences one transaction at a time through load, tick evaluation, the
// least-sleep pass, the round-robin walk and result delivery.
// ----------------------------------------------------------------------------
module rrts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_opcode,
  output logic           in_stall,
  input  rrts_pkg::sts_t sts,
  output rrts_pkg::cmd_t cmd
);

  rrts_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rrts_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_opcode == rrts_pkg::OP_LOAD) ? rrts_pkg::ST_LOAD :
                                                         rrts_pkg::ST_TICK_RD;
        end
      end
      rrts_pkg::ST_LOAD:    state_nxt = rrts_pkg::ST_OUT_RD;
      rrts_pkg::ST_TICK_RD: state_nxt = rrts_pkg::ST_TICK_EV;
      rrts_pkg::ST_TICK_EV: begin
        state_nxt = sts.slice_zero ? rrts_pkg::ST_MIN : rrts_pkg::ST_OUT_RD;
      end
      rrts_pkg::ST_MIN: begin
        if (sts.pass_done) begin
          state_nxt = rrts_pkg::ST_WALK;
        end
      end
      rrts_pkg::ST_WALK: begin
        if (sts.pass_done) begin
          state_nxt = rrts_pkg::ST_OUT_RD;
        end
      end
      rrts_pkg::ST_OUT_RD: state_nxt = rrts_pkg::ST_OUT_WR;
      rrts_pkg::ST_OUT_WR: begin
        if (sts.out_free) begin
          state_nxt = rrts_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rrts_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      rrts_pkg::ST_IDLE: begin
        in_stall     = 1'b0;
        cmd.latch_in = in_valid;
      end
      rrts_pkg::ST_LOAD:    cmd.load_wr = 1'b1;
      rrts_pkg::ST_TICK_RD: cmd.tick_rd = 1'b1;
      rrts_pkg::ST_TICK_EV: cmd.tick_ev = 1'b1;
      rrts_pkg::ST_MIN: begin
        cmd.walk_start = sts.pass_done;
        cmd.min_step   = !sts.pass_done;
      end
      rrts_pkg::ST_WALK:   cmd.walk_step = !sts.pass_done;
      rrts_pkg::ST_OUT_RD: cmd.out_rd = 1'b1;
      rrts_pkg::ST_OUT_WR: cmd.out_wr = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/rrts_dp.sv =====
// ----------------------------------------------------------------------------
// Round-robin timeslice scheduler: datapath
// Slot tables in single-port-read memories, configuration registers, the
// running slot, pass counters and the result register.
// ----------------------------------------------------------------------------
`include "round_robin_timeslice_scheduler_defines.svh"

module rrts_dp #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rrts_pkg::cmd_t                cmd,
  output rrts_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [rrts_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [rrts_pkg::SLOTF_W-1:0]  in_slot_index,
  input  logic [rrts_pkg::PRIO_W-1:0]   in_task_priority,
  input  logic [rrts_pkg::SLEEP_W-1:0]  in_task_sleep,
  input  logic [rrts_pkg::STACK_W-1:0]  in_task_stack,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [rrts_pkg::SLOTF_W-1:0]  out_current_task,
  output logic [rrts_pkg::STACK_W-1:0]  out_stack_pointer,
  output logic                          out_switched
);

  localparam int unsigned SLOT_W = $clog2(MAX_TASKS);
  localparam int unsigned CNT_W  = $clog2(MAX_TASKS + 1);

  // Slot tables
  logic [rrts_pkg::PRIO_W-1:0]  prio_mem  [MAX_TASKS];
  logic [rrts_pkg::SLICE_W-1:0] slice_mem [MAX_TASKS];
  logic [rrts_pkg::SLEEP_W-1:0] sleep_mem [MAX_TASKS];
  logic [rrts_pkg::STACK_W-1:0] stack_mem [MAX_TASKS];

  logic [rrts_pkg::PRIO_W-1:0]  prio_rd_r;
  logic [rrts_pkg::SLICE_W-1:0] slice_rd_r;
  logic [rrts_pkg::SLEEP_W-1:0] sleep_rd_r;
  logic [rrts_pkg::STACK_W-1:0] stack_rd_r;

  // Configuration
  logic [rrts_pkg::SCALE_W-1:0] scale_r;
  logic [rrts_pkg::COUNT_W-1:0] count_r;

  // Captured input transaction
  logic [rrts_pkg::SLOTF_W-1:0] slot_r;
  logic [rrts_pkg::PRIO_W-1:0]  lprio_r;
  logic [rrts_pkg::SLEEP_W-1:0] lsleep_r;
  logic [rrts_pkg::STACK_W-1:0] lstack_r;

  // Scheduling state
  logic [SLOT_W-1:0]            running_r, running_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [SLOT_W-1:0]            pos_r, pos_nxt;
  logic [SLOT_W-1:0]            pa_r, pa_nxt;
  logic                         pv_r, pv_nxt;
  logic                         found_r, found_nxt;
  logic [rrts_pkg::SLEEP_W-1:0] min_r, min_nxt;
  logic                         switched_r;

  // Result register
  logic                         out_valid_r;
  logic [SLOT_W-1:0]            out_slot_r;
  logic [rrts_pkg::STACK_W-1:0] out_stack_r;
  logic                         out_sw_r;

  // Combinational datapath
  logic [CNT_W-1:0]             ring_n;
  logic [SLOT_W-1:0]            start_pos;
  logic [SLOT_W-1:0]            pos_inc;
  logic                         issue;
  logic                         rd_en;
  logic [SLOT_W-1:0]            rd_addr;
  logic                         slot_ok;
  logic [SLOT_W-1:0]            load_addr;
  logic [rrts_pkg::SLICE_W-1:0] load_slice;
  logic [rrts_pkg::SLICE_W-1:0] tick_slice;
  logic [rrts_pkg::SLEEP_W-1:0] lag;
  logic                         slice_we;
  logic [SLOT_W-1:0]            slice_wa;
  logic [rrts_pkg::SLICE_W-1:0] slice_wd;
  logic                         sleep_we;
  logic [SLOT_W-1:0]            sleep_wa;
  logic [rrts_pkg::SLEEP_W-1:0] sleep_wd;

  // Clamp the ring length to one .. MAX_TASKS
  always_comb begin
    if (count_r == '0) begin
      ring_n = CNT_W'(1);
    end else if (32'(count_r) > MAX_TASKS) begin
      ring_n = CNT_W'(MAX_TASKS);
    end else begin
      ring_n = CNT_W'(count_r);
    end
  end

  // Ring successors of the running slot and of the walk position
  assign start_pos = (32'(running_r) + 32'd1 >= 32'(ring_n)) ? '0 : running_r + 1'b1;
  assign pos_inc   = (32'(pos_r) + 32'd1 >= 32'(ring_n)) ? '0 : pos_r + 1'b1;

  assign slot_ok    = 32'(slot_r) < MAX_TASKS;
  assign load_addr  = SLOT_W'(32'(slot_r));
  assign load_slice = rrts_pkg::SLICE_W'(lprio_r) * rrts_pkg::SLICE_W'(scale_r);
  assign tick_slice = rrts_pkg::SLICE_W'(prio_rd_r) * rrts_pkg::SLICE_W'(scale_r);
  assign lag        = sleep_rd_r - min_r;

  // Issue one ring read per cycle during the passes
  assign issue = (cmd.min_step || cmd.walk_step) && (cnt_r != ring_n);
  assign rd_en = cmd.tick_rd || cmd.out_rd || issue;

  always_comb begin
    if (cmd.min_step) begin
      rd_addr = cnt_r[SLOT_W-1:0];
    end else if (cmd.walk_step) begin
      rd_addr = pos_r;
    end else begin
      rd_addr = running_r;
    end
  end

  // Pass counters, least sleep count and walk result
  always_comb begin
    cnt_nxt     = cnt_r;
    pos_nxt     = pos_r;
    pa_nxt      = pa_r;
    pv_nxt      = pv_r;
    found_nxt   = found_r;
    min_nxt     = min_r;
    running_nxt = running_r;
    sleep_we    = 1'b0;
    sleep_wa    = pa_r;
    sleep_wd    = lag;
    if (cmd.tick_ev) begin
      cnt_nxt = '0;
      pv_nxt  = 1'b0;
      min_nxt = '1;
    end
    if (cmd.min_step) begin
      pv_nxt = issue;
      if (issue) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      if (pv_r && (sleep_rd_r < min_r)) begin
        min_nxt = sleep_rd_r;
      end
    end
    if (cmd.walk_start) begin
      cnt_nxt     = '0;
      pos_nxt     = start_pos;
      pv_nxt      = 1'b0;
      found_nxt   = 1'b0;
      running_nxt = start_pos;
    end
    if (cmd.walk_step) begin
      pv_nxt = issue;
      if (issue) begin
        cnt_nxt = cnt_r + 1'b1;
        pos_nxt = pos_inc;
        pa_nxt  = pos_r;
      end
      // Take the lap offset off every slot; decrement skipped sleepers
      if (pv_r) begin
        sleep_we = 1'b1;
        if (!found_r && (lag == '0)) begin
          found_nxt   = 1'b1;
          running_nxt = pa_r;
        end else if (!found_r) begin
          sleep_wd = lag - 1'b1;
        end
      end
    end
    if (cmd.load_wr) begin
      sleep_we = slot_ok;
      sleep_wa = load_addr;
      sleep_wd = lsleep_r;
    end
  end

  // Slice write: loaded value, reload on expiry, or decrement
  always_comb begin
    slice_we = 1'b0;
    slice_wa = running_r;
    slice_wd = slice_rd_r - 1'b1;
    if (cmd.load_wr) begin
      slice_we = slot_ok;
      slice_wa = load_addr;
      slice_wd = load_slice;
    end else if (cmd.tick_ev) begin
      slice_we = 1'b1;
      if (slice_rd_r == '0) begin
        slice_wd = tick_slice;
      end
    end
  end

  // Priority and stack tables
  always_ff @(posedge clk) begin
    if (cmd.load_wr && slot_ok) begin
      prio_mem[load_addr]  <= lprio_r;
      stack_mem[load_addr] <= lstack_r;
    end
    if (rd_en) begin
      prio_rd_r  <= prio_mem[rd_addr];
      stack_rd_r <= stack_mem[rd_addr];
    end
  end

  // Slice table
  always_ff @(posedge clk) begin
    if (slice_we) begin
      slice_mem[slice_wa] <= slice_wd;
    end
    if (rd_en) begin
      slice_rd_r <= slice_mem[rd_addr];
    end
  end

  // Sleep table
  always_ff @(posedge clk) begin
    if (sleep_we) begin
      sleep_mem[sleep_wa] <= sleep_wd;
    end
    if (rd_en) begin
      sleep_rd_r <= sleep_mem[rd_addr];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= rrts_pkg::SCALE_RST;
      count_r <= rrts_pkg::COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == rrts_pkg::REG_SCALE) begin
        scale_r <= cfg_wdata;
      end else begin
        count_r <= cfg_wdata[rrts_pkg::COUNT_W-1:0];
      end
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      slot_r   <= in_slot_index;
      lprio_r  <= in_task_priority;
      lsleep_r <= in_task_sleep;
      lstack_r <= in_task_stack;
    end
  end

  // Scheduling state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= '0;
      pv_r      <= 1'b0;
      cnt_r     <= '0;
      found_r   <= 1'b0;
    end else begin
      running_r <= running_nxt;
      pv_r      <= pv_nxt;
      cnt_r     <= cnt_nxt;
      found_r   <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    pa_r  <= pa_nxt;
    min_r <= min_nxt;
    if (cmd.load_wr) begin
      switched_r <= 1'b0;
    end else if (cmd.tick_ev) begin
      switched_r <= (slice_rd_r == '0);
    end
  end

  // Result register: fill on command, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_wr) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_wr) begin
      out_slot_r  <= running_r;
      out_stack_r <= stack_rd_r;
      out_sw_r    <= switched_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_current_task  = rrts_pkg::SLOTF_W'(32'(out_slot_r));
  assign out_stack_pointer = out_stack_r;
  assign out_switched      = out_sw_r;

  // Status to the controller
  assign sts.slice_zero = (slice_rd_r == '0);
  assign sts.pass_done  = (cnt_r == ring_n) && !pv_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // Checks
  `RRTS_ASSERT_NOW(a_cnt_in_ring, cmd.min_step || cmd.walk_step, 32'(cnt_r) <= 32'(ring_n))
  `RRTS_ASSERT_NOW(a_walk_wr_in_ring, cmd.walk_step && pv_r, 32'(pa_r) < 32'(ring_n))
  `RRTS_ASSERT_NOW(a_out_wr_free, cmd.out_wr, !out_valid_r || !out_stall)
  `RRTS_ASSERT_NEXT(a_out_wr_shows, cmd.out_wr, out_valid_r)

endmodule
